@@ rtl/m61ph_pkg.sv @@
// Shared types and constants for the Mersenne-61 prefix hash table.
// Holds the transaction structs, action and status codes and the links
// between the sequencer, the multiply unit and the table stores.
package m61ph_pkg;

	localparam int MAX_LEN = 1024;
	localparam int LEN_W   = 11;
	localparam int HASH_W  = 61;
	localparam int HALF_W  = 31;
	localparam int PROD_W  = 2 * HALF_W;
	localparam int CFG_W   = 64;
	localparam int PADDR_W = 4;
	localparam int REG_SEL_BIT = 3;

	localparam logic [HASH_W-1:0] HMOD = {HASH_W{1'b1}};
	localparam logic [HASH_W-1:0] BASE_RESET = HASH_W'(2);
	localparam logic REG_HASH_BASE = 1'b0;

	typedef enum logic [1:0] {
		ACT_APPEND  = 2'd0,
		ACT_SUBSTR  = 2'd1,
		ACT_CONCAT  = 2'd2,
		ACT_RESTART = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_BAD  = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	typedef struct packed {
		action_t            action;
		logic [7:0]         char_byte;
		logic [LEN_W-1:0]   left;
		logic [LEN_W-1:0]   right;
		logic [HASH_W-1:0]  hash_a;
		logic [HASH_W-1:0]  hash_b;
		logic [LEN_W-1:0]   length_b;
	} item_t;

	typedef struct packed {
		logic [HASH_W-1:0]  hash_value;
		status_t            status;
		logic [LEN_W-1:0]   string_length;
	} result_t;

	typedef struct packed {
		logic               start;
		logic [HASH_W-1:0]  a;
		logic [HASH_W-1:0]  b;
		logic [HASH_W-1:0]  addend;
	} mul_req_t;

	typedef struct packed {
		logic               done;
		logic [HASH_W-1:0]  result;
	} mul_rsp_t;

	typedef struct packed {
		logic               wh_en;
		logic               wp_en;
		logic [LEN_W-1:0]   waddr;
		logic [HASH_W-1:0]  wdata;
		logic [LEN_W-1:0]   ra;
		logic [LEN_W-1:0]   rb;
		logic [LEN_W-1:0]   rp;
	} store_req_t;

	typedef struct packed {
		logic [HASH_W-1:0]  h_a;
		logic [HASH_W-1:0]  h_b;
		logic [HASH_W-1:0]  p;
	} store_rd_t;

endpackage

@@ rtl/m61ph_mulmod.sv @@
// Iterative multiply-accumulate modulo 2^61-1: addend + a*b.
// Uses one 31x31 multiplier over four partial products; depends on m61ph_pkg.
module m61ph_mulmod (
	input  logic                clk,
	input  logic                arst_n,
	input  m61ph_pkg::mul_req_t req,
	output m61ph_pkg::mul_rsp_t rsp
);
	import m61ph_pkg::*;

	typedef enum logic [1:0] {
		ROT_0  = 2'd0,
		ROT_31 = 2'd1,
		ROT_1  = 2'd2
	} rot_t;

	logic [HASH_W-1:0] a_q, b_q, acc_q, term_q;
	logic [PROD_W-1:0] prod_q;
	rot_t              rot_q;
	logic [2:0]        step_q;
	logic              busy_q, done_q;

	logic [HALF_W-1:0] op_a, op_b;
	rot_t              rot_sel;
	logic [PROD_W-1:0] fold_sum, acc_sum;
	logic [HASH_W-1:0] folded, rotated, acc_next;

	always_comb begin
		case (step_q[1:0])
			2'd0: begin
				op_a = a_q[HALF_W-1:0];
				op_b = b_q[HALF_W-1:0];
				rot_sel = ROT_0;
			end
			2'd1: begin
				op_a = a_q[HALF_W-1:0];
				op_b = {1'b0, b_q[HASH_W-1:HALF_W]};
				rot_sel = ROT_31;
			end
			2'd2: begin
				op_a = {1'b0, a_q[HASH_W-1:HALF_W]};
				op_b = b_q[HALF_W-1:0];
				rot_sel = ROT_31;
			end
			default: begin
				op_a = {1'b0, a_q[HASH_W-1:HALF_W]};
				op_b = {1'b0, b_q[HASH_W-1:HALF_W]};
				rot_sel = ROT_1;
			end
		endcase
	end

	always_comb begin
		fold_sum = {1'b0, prod_q[HASH_W-1:0]} + {{(PROD_W-1){1'b0}}, prod_q[PROD_W-1]};
		if (fold_sum >= {1'b0, HMOD}) begin
			folded = HASH_W'(fold_sum - {1'b0, HMOD});
		end else begin
			folded = fold_sum[HASH_W-1:0];
		end
		case (rot_q)
			ROT_31:  rotated = {folded[29:0], folded[60:30]};
			ROT_1:   rotated = {folded[59:0], folded[60]};
			default: rotated = folded;
		endcase
		acc_sum = {1'b0, acc_q} + {1'b0, term_q};
		if (acc_sum >= {1'b0, HMOD}) begin
			acc_next = HASH_W'(acc_sum - {1'b0, HMOD});
		end else begin
			acc_next = acc_sum[HASH_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 3'd1;
				if (step_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			acc_q <= req.addend;
		end else if (busy_q) begin
			if (step_q <= 3'd3) begin
				prod_q <= op_a * op_b;
				rot_q  <= rot_sel;
			end
			if (step_q >= 3'd1 && step_q <= 3'd4) begin
				term_q <= rotated;
			end
			if (step_q >= 3'd2) begin
				acc_q <= acc_next;
			end
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = acc_q;

endmodule

@@ rtl/m61ph_store.sv @@
// Prefix hash and base power tables with registered reads.
// Entry 0 of each table is supplied by logic; depends on m61ph_pkg.
module m61ph_store (
	input  logic                  clk,
	input  m61ph_pkg::store_req_t req,
	output m61ph_pkg::store_rd_t  rd
);
	import m61ph_pkg::*;

	logic [HASH_W-1:0] hash_mem [0:MAX_LEN];
	logic [HASH_W-1:0] pow_mem  [0:MAX_LEN];

	logic [HASH_W-1:0] h_a_q, h_b_q, p_q;
	logic              za_q, zb_q, zp_q;

	always_ff @(posedge clk) begin
		if (req.wh_en) begin
			hash_mem[req.waddr] <= req.wdata;
		end
		h_a_q <= hash_mem[req.ra];
		h_b_q <= hash_mem[req.rb];
		za_q  <= (req.ra == '0);
		zb_q  <= (req.rb == '0);
	end

	always_ff @(posedge clk) begin
		if (req.wp_en) begin
			pow_mem[req.waddr] <= req.wdata;
		end
		p_q  <= pow_mem[req.rp];
		zp_q <= (req.rp == '0);
	end

	assign rd.h_a = za_q ? '0 : h_a_q;
	assign rd.h_b = zb_q ? '0 : h_b_q;
	assign rd.p   = zp_q ? HASH_W'(1) : p_q;

endmodule

@@ rtl/mersenne61_prefix_hash_table.sv @@
// Top level of the Mersenne-61 prefix hash table: sequencer and APB port.
// An item is taken only when idle; errors and restarts go straight to the done state,
// queries through read, load and one modular multiply, appends through read, load and
// two (power, then hash), all on the shared 31x31 multiplier. A new item waits until
// the last result is moved to the output register. Reset is asynchronous; the base
// returns to 2 and the string to empty, with table entry 0 supplied by logic.
module mersenne61_prefix_hash_table (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  m61ph_pkg::item_t               item,
	output logic                           result_valid,
	input  logic                           result_ready,
	output m61ph_pkg::result_t             result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [m61ph_pkg::PADDR_W-1:0]  paddr,
	input  logic [m61ph_pkg::CFG_W-1:0]    pwdata,
	output logic [m61ph_pkg::CFG_W-1:0]    prdata,
	output logic                           pready
);
	import m61ph_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_READ  = 6'b000010,
		S_LOAD  = 6'b000100,
		S_MUL_P = 6'b001000,
		S_MUL_H = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t            state_q;
	logic [LEN_W-1:0]  len_q;
	logic [HASH_W-1:0] hash_base_q;
	logic              result_valid_q;
	item_t             item_q;
	result_t           res_q, result_q;

	mul_req_t   mreq;
	mul_rsp_t   mrsp;
	store_req_t sreq;
	store_rd_t  srd;

	logic accept, deliver, bad_item;
	logic [LEN_W-1:0] len_next;

	m61ph_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	m61ph_store u_store (
		.clk (clk),
		.req (sreq),
		.rd  (srd)
	);

	assign item_ready   = (state_q == S_IDLE);
	assign accept       = item_valid && item_ready;
	assign deliver      = (state_q == S_DONE) && (!result_valid_q || result_ready);
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign pready       = 1'b1;
	assign prdata       = (paddr[REG_SEL_BIT] == REG_HASH_BASE) ?
	                      CFG_W'(hash_base_q) : '0;
	assign len_next     = len_q + LEN_W'(1);

	always_comb begin
		unique case (item.action)
			ACT_APPEND:  bad_item = (len_q >= LEN_W'(MAX_LEN));
			ACT_SUBSTR:  bad_item = (item.left > item.right) || (item.right > len_q);
			ACT_CONCAT:  bad_item = (item.length_b > len_q);
			default:     bad_item = 1'b1;
		endcase
	end

	always_comb begin
		sreq.ra    = (item_q.action == ACT_APPEND) ? len_q : item_q.left;
		sreq.rb    = item_q.right;
		unique case (item_q.action)
			ACT_APPEND: sreq.rp = len_q;
			ACT_SUBSTR: sreq.rp = item_q.right - item_q.left;
			default:    sreq.rp = item_q.length_b;
		endcase
		sreq.waddr = len_next;
		sreq.wdata = mrsp.result;
		sreq.wp_en = (state_q == S_MUL_P) && mrsp.done;
		sreq.wh_en = (state_q == S_MUL_H) && mrsp.done && (item_q.action == ACT_APPEND);

		mreq = '0;
		if (state_q == S_LOAD) begin
			mreq.start = 1'b1;
			unique case (item_q.action)
				ACT_APPEND: begin
					mreq.a      = srd.p;
					mreq.b      = hash_base_q;
					mreq.addend = '0;
				end
				ACT_SUBSTR: begin
					mreq.a      = srd.h_a;
					mreq.b      = HMOD - srd.p;
					mreq.addend = srd.h_b;
				end
				default: begin
					mreq.a      = item_q.hash_a;
					mreq.b      = srd.p;
					mreq.addend = item_q.hash_b;
				end
			endcase
		end else if ((state_q == S_MUL_P) && mrsp.done) begin
			mreq.start  = 1'b1;
			mreq.a      = srd.h_a;
			mreq.b      = hash_base_q;
			mreq.addend = HASH_W'(item_q.char_byte);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			len_q          <= '0;
			hash_base_q    <= BASE_RESET;
			result_valid_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite && (paddr[REG_SEL_BIT] == REG_HASH_BASE)) begin
				hash_base_q <= pwdata[HASH_W-1:0];
			end
			if (deliver) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.action == ACT_RESTART) begin
							len_q   <= '0;
							state_q <= S_DONE;
						end else if (bad_item) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_READ:  state_q <= S_LOAD;
				S_LOAD:  state_q <= (item_q.action == ACT_APPEND) ? S_MUL_P : S_MUL_H;
				S_MUL_P: begin
					if (mrsp.done) begin
						state_q <= S_MUL_H;
					end
				end
				S_MUL_H: begin
					if (mrsp.done) begin
						if (item_q.action == ACT_APPEND) begin
							len_q <= len_next;
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (deliver) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
			res_q.hash_value <= '0;
			if (item.action == ACT_RESTART) begin
				res_q.status        <= STAT_OK;
				res_q.string_length <= '0;
			end else begin
				res_q.status        <= (item.action == ACT_APPEND) ? STAT_FULL : STAT_BAD;
				res_q.string_length <= len_q;
			end
		end else if ((state_q == S_MUL_H) && mrsp.done) begin
			res_q.hash_value    <= mrsp.result;
			res_q.status        <= STAT_OK;
			res_q.string_length <= (item_q.action == ACT_APPEND) ? len_next : len_q;
		end
		if (deliver) begin
			result_q <= res_q;
		end
	end

	// The stored length never passes the table depth.
	assert property (@(posedge clk) disable iff (!arst_n) len_q <= LEN_W'(MAX_LEN))
		else $error("stored length beyond table depth");

	// The multiply unit only finishes while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		mrsp.done |-> (state_q == S_MUL_P || state_q == S_MUL_H))
		else $error("multiply finished outside a multiply state");

	// The length changes only on a restart or at the end of an append.
	assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(len_q) |-> ($past(state_q) == S_MUL_H || $past(state_q) == S_IDLE))
		else $error("stored length changed unexpectedly");

	// A table write always targets the entry just beyond the stored string.
	assert property (@(posedge clk) disable iff (!arst_n)
		(sreq.wh_en || sreq.wp_en) |->
			(sreq.waddr == len_q + LEN_W'(1)) && (len_q < LEN_W'(MAX_LEN)))
		else $error("table write outside the append position");

endmodule
